### src/xqsed_pkg.sv
`default_nettype none

package xqsed_pkg;

	localparam int unsigned BUFFER_DEPTH_DEF = 16;
	localparam int unsigned ACC_WIDTH_DEF    = 32;
	localparam int unsigned CHAR_W           = 16;
	localparam int unsigned QUOTE_W          = 6;
	localparam int unsigned DFA_W            = 5;
	localparam int unsigned CLS_W            = 5;
	localparam int unsigned DIGIT_W          = 4;

	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [QUOTE_W-1:0] quote_t;
	typedef logic [DFA_W-1:0]   dfa_t;
	typedef logic [CLS_W-1:0]   cls_t;
	typedef logic [DIGIT_W-1:0] digit_t;

	localparam quote_t QUOTE_RESET = 6'd34;

	// character codes
	localparam char_t CH_DQUOTE = 16'h0022;
	localparam char_t CH_HASH   = 16'h0023;
	localparam char_t CH_AMP    = 16'h0026;
	localparam char_t CH_APOS   = 16'h0027;
	localparam char_t CH_0      = 16'h0030;
	localparam char_t CH_9      = 16'h0039;
	localparam char_t CH_SEMI   = 16'h003B;
	localparam char_t CH_LT     = 16'h003C;
	localparam char_t CH_GT     = 16'h003E;
	localparam char_t CH_UA     = 16'h0041;
	localparam char_t CH_UF     = 16'h0046;
	localparam char_t CH_LA     = 16'h0061;
	localparam char_t CH_LB     = 16'h0062;
	localparam char_t CH_LF     = 16'h0066;
	localparam char_t CH_LG     = 16'h0067;
	localparam char_t CH_LL     = 16'h006C;
	localparam char_t CH_LM     = 16'h006D;
	localparam char_t CH_LO     = 16'h006F;
	localparam char_t CH_LP     = 16'h0070;
	localparam char_t CH_LQ     = 16'h0071;
	localparam char_t CH_LS     = 16'h0073;
	localparam char_t CH_LT_T   = 16'h0074;
	localparam char_t CH_LU     = 16'h0075;
	localparam char_t CH_LX     = 16'h0078;

	// character classes
	localparam cls_t CL_QUOTE  = 5'd1;
	localparam cls_t CL_AMP    = 5'd2;
	localparam cls_t CL_HASH   = 5'd3;
	localparam cls_t CL_X      = 5'd4;
	localparam cls_t CL_SEMI   = 5'd5;
	localparam cls_t CL_OTHER  = 5'd6;
	localparam cls_t CL_A      = 5'd7;
	localparam cls_t CL_M      = 5'd8;
	localparam cls_t CL_P      = 5'd9;
	localparam cls_t CL_Q      = 5'd10;
	localparam cls_t CL_U      = 5'd11;
	localparam cls_t CL_O      = 5'd12;
	localparam cls_t CL_T      = 5'd13;
	localparam cls_t CL_S      = 5'd14;
	localparam cls_t CL_L      = 5'd15;
	localparam cls_t CL_G      = 5'd16;
	localparam cls_t CL_HEXLET = 5'd17;
	localparam cls_t CL_DIGIT  = 5'd18;

	// parser states
	localparam dfa_t DS_ERROR   = 5'd0;
	localparam dfa_t DS_START   = 5'd1;
	localparam dfa_t DS_TEXT    = 5'd2;
	localparam dfa_t DS_CLOSED  = 5'd3;
	localparam dfa_t DS_AMP     = 5'd4;
	localparam dfa_t DS_L       = 5'd5;
	localparam dfa_t DS_G       = 5'd6;
	localparam dfa_t DS_Q       = 5'd7;
	localparam dfa_t DS_A       = 5'd8;
	localparam dfa_t DS_AM      = 5'd9;
	localparam dfa_t DS_AP      = 5'd10;
	localparam dfa_t DS_LT      = 5'd11;
	localparam dfa_t DS_GT      = 5'd12;
	localparam dfa_t DS_QU      = 5'd13;
	localparam dfa_t DS_HASH    = 5'd14;
	localparam dfa_t DS_AMP_END = 5'd15;
	localparam dfa_t DS_APO     = 5'd16;
	localparam dfa_t DS_APOS    = 5'd17;
	localparam dfa_t DS_QUO     = 5'd18;
	localparam dfa_t DS_QUOT    = 5'd19;
	localparam dfa_t DS_DEC     = 5'd20;
	localparam dfa_t DS_HEX_X   = 5'd21;
	localparam dfa_t DS_HEX     = 5'd22;

	typedef enum logic [1:0] {
		ALU_MAC10,
		ALU_MAC16,
		ALU_LT
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		digit_t  digit;
	} alu_ctl_t;

	function automatic cls_t classify(input char_t c, input quote_t q);
		cls_t cl;
		if (c == CH_DQUOTE || c == CH_APOS) begin
			cl = (c == {{(CHAR_W-QUOTE_W){1'b0}}, q}) ? CL_QUOTE : CL_OTHER;
		end else begin
			unique case (c) inside
				[CH_0:CH_9]:   cl = CL_DIGIT;
				[CH_UA:CH_UF]: cl = CL_HEXLET;
				[CH_LB:CH_LF]: cl = CL_HEXLET;
				CH_AMP:        cl = CL_AMP;
				CH_HASH:       cl = CL_HASH;
				CH_LX:         cl = CL_X;
				CH_SEMI:       cl = CL_SEMI;
				CH_LA:         cl = CL_A;
				CH_LM:         cl = CL_M;
				CH_LP:         cl = CL_P;
				CH_LQ:         cl = CL_Q;
				CH_LU:         cl = CL_U;
				CH_LO:         cl = CL_O;
				CH_LT_T:       cl = CL_T;
				CH_LS:         cl = CL_S;
				CH_LL:         cl = CL_L;
				CH_LG:         cl = CL_G;
				default:       cl = CL_OTHER;
			endcase
		end
		return cl;
	endfunction

	// transition table: any live state other than start and closed falls back
	// to text, returns to closed on the quote and opens an entity on '&'
	function automatic dfa_t leap_next(input dfa_t st, input cls_t cl);
		dfa_t nx;
		if (st == DS_START) begin
			nx = (cl == CL_QUOTE) ? DS_TEXT : DS_ERROR;
		end else if (st == DS_ERROR || st == DS_CLOSED || st > DS_HEX) begin
			nx = DS_ERROR;
		end else if (cl == CL_QUOTE) begin
			nx = DS_CLOSED;
		end else if (cl == CL_AMP) begin
			nx = DS_AMP;
		end else begin
			nx = DS_TEXT;
			unique case (st)
				DS_AMP: begin
					unique case (cl)
						CL_HASH: nx = DS_HASH;
						CL_A:    nx = DS_A;
						CL_Q:    nx = DS_Q;
						CL_L:    nx = DS_L;
						CL_G:    nx = DS_G;
						default: nx = DS_TEXT;
					endcase
				end
				DS_L:     if (cl == CL_T) nx = DS_LT;
				DS_G:     if (cl == CL_T) nx = DS_GT;
				DS_Q:     if (cl == CL_U) nx = DS_QU;
				DS_A: begin
					if (cl == CL_M) nx = DS_AM;
					else if (cl == CL_P) nx = DS_AP;
				end
				DS_AM:    if (cl == CL_P) nx = DS_AMP_END;
				DS_AP:    if (cl == CL_O) nx = DS_APO;
				DS_QU:    if (cl == CL_O) nx = DS_QUO;
				DS_HASH: begin
					if (cl == CL_X) nx = DS_HEX_X;
					else if (cl == CL_DIGIT) nx = DS_DEC;
				end
				DS_APO:   if (cl == CL_S) nx = DS_APOS;
				DS_QUO:   if (cl == CL_T) nx = DS_QUOT;
				DS_DEC:   if (cl == CL_DIGIT) nx = DS_DEC;
				DS_HEX_X, DS_HEX: begin
					if (cl == CL_A || cl == CL_HEXLET || cl == CL_DIGIT) nx = DS_HEX;
				end
				default:  nx = DS_TEXT;
			endcase
		end
		return nx;
	endfunction

	function automatic digit_t hex_value(input char_t c);
		digit_t v;
		if (c >= CH_0 && c <= CH_9) begin
			v = c[DIGIT_W-1:0];
		end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
			v = c[DIGIT_W-1:0] + 4'd9;
		end else begin
			v = '0;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

### src/xqsed_if.sv
`default_nettype none

interface xqsed_in_if;
	logic                      valid;
	logic                      ready;
	logic [xqsed_pkg::CHAR_W-1:0] in_char;
	logic                      start_string;

	modport source (output valid, output in_char, output start_string, input ready);
	modport sink   (input valid, input in_char, input start_string, output ready);
endinterface

interface xqsed_out_if;
	logic                      valid;
	logic                      ready;
	logic [xqsed_pkg::CHAR_W-1:0] out_char;
	logic                      has_char;
	logic                      last_of_run;
	logic                      string_done;
	logic                      syntax_error;
	logic                      wide_entity;
	logic                      buffer_overflow;

	modport source (
		output valid, output out_char, output has_char, output last_of_run,
		output string_done, output syntax_error, output wide_entity,
		output buffer_overflow, input ready
	);
	modport sink (
		input valid, input out_char, input has_char, input last_of_run,
		input string_done, input syntax_error, input wide_entity,
		input buffer_overflow, output ready
	);
endinterface

`default_nettype wire

### src/xqsed_ram.sv
`default_nettype none

module xqsed_ram #(
	parameter int unsigned WIDTH = xqsed_pkg::CHAR_W,
	parameter int unsigned DEPTH = xqsed_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### src/xqsed_alu.sv
`default_nettype none

module xqsed_alu #(
	parameter int unsigned WIDTH = xqsed_pkg::ACC_WIDTH_DEF
) (
	input  wire xqsed_pkg::alu_ctl_t ctl,
	input  wire logic [WIDTH-1:0]    a,
	input  wire logic [WIDTH-1:0]    b,
	output      logic [WIDTH-1:0]    res,
	output      logic                lt
);

	// multiply-accumulate wraps modulo 2^WIDTH
	always_comb begin
		res = a;
		lt  = 1'b0;
		unique case (ctl.op)
			xqsed_pkg::ALU_MAC10: res = (a << 3) + (a << 1) + WIDTH'(ctl.digit);
			xqsed_pkg::ALU_MAC16: res = (a << 4) + WIDTH'(ctl.digit);
			xqsed_pkg::ALU_LT:    lt  = (a < b);
			default:              res = a;
		endcase
	end

endmodule

`default_nettype wire

### src/xml_quoted_string_entity_decoder.sv
`default_nettype none

// Decoder for the characters of one quoted XML string, opening quote first.
// enc carries one 16-bit code unit per item plus start_string, which resets
// the parse before that code unit. dec carries decoded characters; every
// input item yields at least one result and its final result has
// last_of_run set (an item with nothing to show gives has_char low).
// cfg_wr_en/cfg_wr_data set the delimiting quote and may be written only
// while the block is idle.
// Sequencing: plain text and named or numeric entity ends pass through the
// result state, a numeric digit makes one pass through the shared
// multiply-accumulate unit and one through its compare, and buffered entity
// characters are flushed from the buffer RAM through a read state and an
// emit state for each character, as its read port is registered. enc.ready is
// high only when the sequencer is idle.
// Results sit in an output register: a stalled receiver holds the current
// result and the sequencer waits before producing the next one, but a new
// input item is still taken once the previous one has handed over its last
// result. Reset returns the parse to its start state, clears the parse flags
// and sets the quote to the double quote; the buffer RAM needs no clearing.
module xml_quoted_string_entity_decoder #(
	parameter int unsigned BUFFER_DEPTH = xqsed_pkg::BUFFER_DEPTH_DEF,
	parameter int unsigned ACC_WIDTH    = xqsed_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [xqsed_pkg::QUOTE_W-1:0] cfg_wr_data,
	xqsed_in_if.sink                           enc,
	xqsed_out_if.source                        dec
);

	localparam int unsigned AW    = $clog2(BUFFER_DEPTH);
	localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_MAC    = 6'b000010,
		S_CMP    = 6'b000100,
		S_RD     = 6'b001000,
		S_EMIT   = 6'b010000,
		S_RESULT = 6'b100000
	} fsm_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_ECHO,
		ACT_ENTITY,
		ACT_PUSH,
		ACT_PUSH_FLUSH,
		ACT_FLUSH,
		ACT_AMP,
		ACT_NUM
	} act_t;

	fsm_t                    fsm_q;
	xqsed_pkg::dfa_t         state_q;
	logic [CNT_W-1:0]        count_q;
	logic [ACC_WIDTH-1:0]    acc_q;
	logic [ACC_WIDTH-1:0]    prv_q;
	logic                    big_q;
	logic                    nc_q;
	logic                    ovf_q;
	xqsed_pkg::quote_t       quote_q;
	logic                    out_vld_q;

	xqsed_pkg::char_t        c_q;
	xqsed_pkg::char_t        res_char_q;
	logic                    res_has_q;
	logic                    base16_q;
	xqsed_pkg::digit_t       digit_q;
	logic [CNT_W-1:0]        flush_n_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    push0_q;
	xqsed_pkg::char_t        out_char_q;
	logic                    out_has_q;
	logic                    out_last_q;
	logic                    out_done_q;
	logic                    out_err_q;
	logic                    out_wide_q;
	logic                    out_ovf_q;

	logic                    start;
	xqsed_pkg::dfa_t         st_e;
	xqsed_pkg::dfa_t         nxt;
	xqsed_pkg::cls_t         cls;
	logic [CNT_W-1:0]        cnt_e;
	logic [ACC_WIDTH-1:0]    acc_e;
	logic                    big_e;
	logic                    fits;
	logic                    named_end;
	act_t                    act;
	xqsed_pkg::char_t        ent_char;
	logic                    ent_wide;

	logic [CNT_W-1:0]        cnt_nx;
	logic [ACC_WIDTH-1:0]    acc_nx;
	logic [ACC_WIDTH-1:0]    prv_nx;
	logic                    nc_nx;
	logic                    ovf_nx;
	fsm_t                    fsm_nx;

	logic                    accept;
	logic                    out_free;
	logic                    load;
	logic [CNT_W-1:0]        idx_nx;
	logic                    emit_last;

	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	xqsed_pkg::char_t        wr_data;
	xqsed_pkg::char_t        rd_data;

	xqsed_pkg::alu_ctl_t     alu_ctl;
	logic [ACC_WIDTH-1:0]    alu_res;
	logic                    alu_lt;

	// decide the action for the offered item, with start_string already applied
	always_comb begin
		start = enc.start_string;
		st_e  = start ? xqsed_pkg::DS_START : state_q;
		cnt_e = start ? '0 : count_q;
		acc_e = start ? '0 : acc_q;
		big_e = start ? 1'b0 : big_q;
		cls   = xqsed_pkg::classify(enc.in_char, quote_q);
		nxt   = xqsed_pkg::leap_next(st_e, cls);
		fits  = (cnt_e < DEPTH_CNT);

		named_end = (st_e == xqsed_pkg::DS_LT) || (st_e == xqsed_pkg::DS_GT) ||
		            (st_e == xqsed_pkg::DS_AMP_END) || (st_e == xqsed_pkg::DS_APOS) ||
		            (st_e == xqsed_pkg::DS_QUOT) || (st_e == xqsed_pkg::DS_DEC) ||
		            (st_e == xqsed_pkg::DS_HEX);

		if (nxt == xqsed_pkg::DS_ERROR) begin
			act = ACT_NONE;
		end else if (nxt == xqsed_pkg::DS_TEXT) begin
			if (st_e == xqsed_pkg::DS_TEXT) begin
				act = ACT_ECHO;
			end else if (st_e == xqsed_pkg::DS_START) begin
				act = ACT_NONE;
			end else if (enc.in_char == xqsed_pkg::CH_SEMI && named_end) begin
				act = ACT_ENTITY;
			end else begin
				act = ACT_PUSH_FLUSH;
			end
		end else if (nxt == xqsed_pkg::DS_CLOSED) begin
			act = (st_e != xqsed_pkg::DS_START && st_e != xqsed_pkg::DS_TEXT) ?
			      ACT_FLUSH : ACT_NONE;
		end else if (nxt == xqsed_pkg::DS_AMP) begin
			act = ACT_AMP;
		end else if (nxt == xqsed_pkg::DS_DEC || nxt == xqsed_pkg::DS_HEX) begin
			act = ACT_NUM;
		end else begin
			act = ACT_PUSH;
		end

		unique case (st_e)
			xqsed_pkg::DS_LT:      ent_char = xqsed_pkg::CH_LT;
			xqsed_pkg::DS_GT:      ent_char = xqsed_pkg::CH_GT;
			xqsed_pkg::DS_AMP_END: ent_char = xqsed_pkg::CH_AMP;
			xqsed_pkg::DS_APOS:    ent_char = xqsed_pkg::CH_APOS;
			xqsed_pkg::DS_QUOT:    ent_char = xqsed_pkg::CH_DQUOTE;
			default:               ent_char = acc_e[xqsed_pkg::CHAR_W-1:0];
		endcase
		ent_wide = (st_e == xqsed_pkg::DS_DEC || st_e == xqsed_pkg::DS_HEX) &&
		           ((|acc_e[ACC_WIDTH-1:8]) || big_e);
	end

	// register values taken when an item is accepted
	always_comb begin
		cnt_nx = cnt_e;
		acc_nx = acc_e;
		prv_nx = start ? '0 : prv_q;
		nc_nx  = start ? 1'b0 : nc_q;
		ovf_nx = start ? 1'b0 : ovf_q;
		fsm_nx = S_RESULT;
		case (act)
			ACT_ENTITY: begin
				cnt_nx = '0;
				if (ent_wide) nc_nx = 1'b1;
			end
			ACT_PUSH: begin
				if (fits) cnt_nx = cnt_e + 1'b1;
				else ovf_nx = 1'b1;
			end
			ACT_PUSH_FLUSH: begin
				if (fits) cnt_nx = cnt_e + 1'b1;
				else ovf_nx = 1'b1;
				fsm_nx = S_RD;
			end
			ACT_FLUSH: begin
				if (cnt_e != '0) fsm_nx = S_RD;
			end
			ACT_AMP: begin
				if (st_e == xqsed_pkg::DS_TEXT || cnt_e == '0) cnt_nx = CNT_ONE;
				else fsm_nx = S_RD;
			end
			ACT_NUM: begin
				if (fits) cnt_nx = cnt_e + 1'b1;
				else ovf_nx = 1'b1;
				// first digit of a reference starts a fresh value
				if (st_e == xqsed_pkg::DS_HASH || st_e == xqsed_pkg::DS_HEX_X) begin
					acc_nx = '0;
					prv_nx = '0;
				end
				fsm_nx = S_MAC;
			end
			default: ;
		endcase
	end

	assign accept    = enc.valid && (fsm_q == S_IDLE);
	assign out_free  = !out_vld_q || dec.ready;
	assign load      = ((fsm_q == S_RESULT) || (fsm_q == S_EMIT)) && out_free;
	assign idx_nx    = idx_q + 1'b1;
	assign emit_last = (idx_nx == flush_n_q);

	// buffer writes: the item itself on accept, or the held '&' after a flush
	always_comb begin
		wr_en = 1'b0;
		if (accept) begin
			if ((act == ACT_PUSH || act == ACT_PUSH_FLUSH || act == ACT_NUM) && fits) begin
				wr_en = 1'b1;
			end
			if (act == ACT_AMP && (st_e == xqsed_pkg::DS_TEXT || cnt_e == '0)) begin
				wr_en = 1'b1;
			end
		end else if (fsm_q == S_EMIT && out_free && emit_last && push0_q) begin
			wr_en = 1'b1;
		end
		wr_addr = (accept && act != ACT_AMP) ? cnt_e[AW-1:0] : '0;
		wr_data = accept ? enc.in_char : c_q;
	end

	xqsed_ram #(
		.WIDTH (xqsed_pkg::CHAR_W),
		.DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (fsm_q == S_RD),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		alu_ctl.op    = (fsm_q == S_CMP) ? xqsed_pkg::ALU_LT :
		                (base16_q ? xqsed_pkg::ALU_MAC16 : xqsed_pkg::ALU_MAC10);
		alu_ctl.digit = digit_q;
	end

	xqsed_alu #(
		.WIDTH (ACC_WIDTH)
	) u_alu (
		.ctl (alu_ctl),
		.a   (acc_q),
		.b   (prv_q),
		.res (alu_res),
		.lt  (alu_lt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= S_IDLE;
			state_q   <= xqsed_pkg::DS_START;
			count_q   <= '0;
			acc_q     <= '0;
			prv_q     <= '0;
			big_q     <= 1'b0;
			nc_q      <= 1'b0;
			ovf_q     <= 1'b0;
			quote_q   <= xqsed_pkg::QUOTE_RESET;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				quote_q <= cfg_wr_data;
			end
			out_vld_q <= load || (out_vld_q && !dec.ready);

			unique case (fsm_q)
				S_IDLE: begin
					if (enc.valid) begin
						state_q <= nxt;
						count_q <= cnt_nx;
						acc_q   <= acc_nx;
						prv_q   <= prv_nx;
						big_q   <= big_e;
						nc_q    <= nc_nx;
						ovf_q   <= ovf_nx;
						fsm_q   <= fsm_nx;
					end
				end
				S_MAC: begin
					acc_q <= alu_res;
					fsm_q <= S_CMP;
				end
				S_CMP: begin
					if (alu_lt) big_q <= 1'b1;
					else prv_q <= acc_q;
					fsm_q <= S_RESULT;
				end
				S_RD: begin
					fsm_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (emit_last) begin
							count_q <= push0_q ? CNT_ONE : '0;
							fsm_q   <= S_IDLE;
						end else begin
							fsm_q <= S_RD;
						end
					end
				end
				S_RESULT: begin
					if (out_free) fsm_q <= S_IDLE;
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q        <= enc.in_char;
			res_char_q <= (act == ACT_ECHO) ? enc.in_char :
			              (act == ACT_ENTITY) ? ent_char : '0;
			res_has_q  <= (act == ACT_ECHO) || (act == ACT_ENTITY);
			base16_q   <= (nxt == xqsed_pkg::DS_HEX);
			digit_q    <= xqsed_pkg::hex_value(enc.in_char);
			idx_q      <= '0;
			push0_q    <= (act == ACT_AMP);
			flush_n_q  <= (act == ACT_PUSH_FLUSH && fits) ? cnt_e + 1'b1 : cnt_e;
		end else if (fsm_q == S_EMIT && out_free) begin
			idx_q <= idx_nx;
		end

		if (load) begin
			out_char_q <= (fsm_q == S_EMIT) ? rd_data : res_char_q;
			out_has_q  <= (fsm_q == S_EMIT) ? 1'b1 : res_has_q;
			out_last_q <= (fsm_q == S_EMIT) ? emit_last : 1'b1;
			out_done_q <= (state_q == xqsed_pkg::DS_CLOSED);
			out_err_q  <= (state_q == xqsed_pkg::DS_ERROR);
			out_wide_q <= nc_q;
			out_ovf_q  <= ovf_q;
		end
	end

	assign enc.ready           = (fsm_q == S_IDLE);
	assign dec.valid           = out_vld_q;
	assign dec.out_char        = out_char_q;
	assign dec.has_char        = out_has_q;
	assign dec.last_of_run     = out_last_q;
	assign dec.string_done     = out_done_q;
	assign dec.syntax_error    = out_err_q;
	assign dec.wide_entity     = out_wide_q;
	assign dec.buffer_overflow = out_ovf_q;

endmodule

`default_nettype wire

### bench/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import xqsed_pkg::*;

	localparam int unsigned ENT_DEPTH = BUFFER_DEPTH_DEF;
	localparam int unsigned BYTE_MAX  = 255;

	typedef struct packed {
		char_t ch;
		logic  restart;
	} unit_t;

	typedef struct packed {
		char_t ch;
		logic  has;
		logic  last_run;
		logic  done;
		logic  err;
		logic  wide;
		logic  ovf;
	} dec_result_t;

	logic   clk;
	logic   arst_n;
	logic   cfg_wr_en;
	quote_t cfg_wr_data;

	xqsed_in_if  in_ch ();
	xqsed_out_if out_ch ();

	xml_quoted_string_entity_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.enc        (in_ch),
		.dec        (out_ch)
	);

	// decoder state as the parse sees it
	dfa_t                     step_tbl [0:DS_HEX][1:CL_DIGIT];
	quote_t                   quote_cfg;
	dfa_t                     parse_st;
	char_t                    ent_buf [ENT_DEPTH];
	int unsigned              ent_n;
	logic [ACC_WIDTH_DEF-1:0] acc;
	logic [ACC_WIDTH_DEF-1:0] acc_prev;
	logic                     acc_big;
	logic                     wide_flag;
	logic                     ovf_flag;
	char_t                    emitted [$];

	unit_t       units_q [$];
	dec_result_t decoded_q [$];
	int unsigned queued_n;
	int unsigned mismatch_n;

	unit_t       next_unit;
	int unsigned gap_n;
	logic        calm_in;
	dec_result_t got;
	dec_result_t want;
	int unsigned hold_n;
	int unsigned wait_n;
	logic        calm_out;

	string hex_digits  = "0123456789abcdefABCDEF";
	string plain_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGXYZ0123456789#;<> ";

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// transition table: live states fall back to text, close on the quote, open on '&'
	initial begin
		for (int s = 0; s <= DS_HEX; s++) begin
			for (int k = 1; k <= CL_DIGIT; k++) begin
				step_tbl[s][k] = (s == DS_TEXT || s > DS_CLOSED) ? DS_TEXT : DS_ERROR;
			end
			if (s == DS_TEXT || s > DS_CLOSED) begin
				step_tbl[s][CL_QUOTE] = DS_CLOSED;
				step_tbl[s][CL_AMP]   = DS_AMP;
			end
		end
		step_tbl[DS_START][CL_QUOTE]  = DS_TEXT;
		step_tbl[DS_AMP][CL_HASH]     = DS_HASH;
		step_tbl[DS_AMP][CL_A]        = DS_A;
		step_tbl[DS_AMP][CL_Q]        = DS_Q;
		step_tbl[DS_AMP][CL_L]        = DS_L;
		step_tbl[DS_AMP][CL_G]        = DS_G;
		step_tbl[DS_L][CL_T]          = DS_LT;
		step_tbl[DS_G][CL_T]          = DS_GT;
		step_tbl[DS_Q][CL_U]          = DS_QU;
		step_tbl[DS_A][CL_M]          = DS_AM;
		step_tbl[DS_A][CL_P]          = DS_AP;
		step_tbl[DS_AM][CL_P]         = DS_AMP_END;
		step_tbl[DS_AP][CL_O]         = DS_APO;
		step_tbl[DS_QU][CL_O]         = DS_QUO;
		step_tbl[DS_HASH][CL_X]       = DS_HEX_X;
		step_tbl[DS_HASH][CL_DIGIT]   = DS_DEC;
		step_tbl[DS_APO][CL_S]        = DS_APOS;
		step_tbl[DS_QUO][CL_T]        = DS_QUOT;
		step_tbl[DS_DEC][CL_DIGIT]    = DS_DEC;
		step_tbl[DS_HEX_X][CL_A]      = DS_HEX;
		step_tbl[DS_HEX_X][CL_HEXLET] = DS_HEX;
		step_tbl[DS_HEX_X][CL_DIGIT]  = DS_HEX;
		step_tbl[DS_HEX][CL_A]        = DS_HEX;
		step_tbl[DS_HEX][CL_HEXLET]   = DS_HEX;
		step_tbl[DS_HEX][CL_DIGIT]    = DS_HEX;
		quote_cfg = QUOTE_RESET;
		restart_parse();
	end

	function automatic cls_t char_class(input char_t c);
		if (c == CH_DQUOTE || c == CH_APOS) return (char_t'(quote_cfg) == c) ? CL_QUOTE : CL_OTHER;
		if (c >= CH_0 && c <= CH_9) return CL_DIGIT;
		if (c >= CH_UA && c <= CH_UF) return CL_HEXLET;
		if (c >= CH_LB && c <= CH_LF) return CL_HEXLET;
		case (c)
			CH_AMP:  return CL_AMP;
			CH_HASH: return CL_HASH;
			CH_LX:   return CL_X;
			CH_SEMI: return CL_SEMI;
			CH_LA:   return CL_A;
			CH_LM:   return CL_M;
			CH_LP:   return CL_P;
			CH_LQ:   return CL_Q;
			CH_LU:   return CL_U;
			CH_LO:   return CL_O;
			CH_LT_T: return CL_T;
			CH_LS:   return CL_S;
			CH_LL:   return CL_L;
			CH_LG:   return CL_G;
			default: return CL_OTHER;
		endcase
	endfunction

	task automatic restart_parse();
		parse_st  = DS_START;
		ent_n     = 0;
		acc       = '0;
		acc_prev  = '0;
		acc_big   = 1'b0;
		wide_flag = 1'b0;
		ovf_flag  = 1'b0;
	endtask

	task automatic stash(input char_t c);
		if (ent_n < ENT_DEPTH) begin
			ent_buf[ent_n] = c;
			ent_n++;
		end else begin
			ovf_flag = 1'b1;
		end
	endtask

	task automatic spill();
		for (int i = 0; i < ent_n; i++) emitted.push_back(ent_buf[i]);
		ent_n = 0;
	endtask

	task automatic fold_digit(input logic [ACC_WIDTH_DEF-1:0] base,
			input logic [ACC_WIDTH_DEF-1:0] d);
		acc = acc * base + d;
		if (acc < acc_prev) acc_big = 1'b1;
		else acc_prev = acc;
	endtask

	// advance the parse by one code unit and queue the results it yields
	task automatic decode_unit(input char_t c, input logic restart);
		dfa_t                     was;
		char_t                    named;
		logic                     ended;
		logic [ACC_WIDTH_DEF-1:0] nib;
		dec_result_t              r;
		emitted.delete();
		if (restart) restart_parse();
		if (parse_st != DS_ERROR) begin
			was      = parse_st;
			parse_st = step_tbl[was][char_class(c)];
			case (parse_st)
				DS_ERROR: ;
				DS_TEXT: begin
					if (was == DS_TEXT) begin
						emitted.push_back(c);
					end else if (was != DS_START) begin
						ended = 1'b0;
						named = '0;
						if (c == CH_SEMI) begin
							ended = 1'b1;
							case (was)
								DS_LT:      named = CH_LT;
								DS_GT:      named = CH_GT;
								DS_AMP_END: named = CH_AMP;
								DS_APOS:    named = CH_APOS;
								DS_QUOT:    named = CH_DQUOTE;
								DS_DEC, DS_HEX: begin
									if (acc > BYTE_MAX || acc_big) wide_flag = 1'b1;
									named = acc[CHAR_W-1:0];
								end
								default: ended = 1'b0;
							endcase
						end
						if (ended) begin
							ent_n = 0;
							emitted.push_back(named);
						end else begin
							// broken entity: flush it out as it came
							stash(c);
							spill();
						end
					end
				end
				DS_CLOSED: begin
					if (was != DS_START && was != DS_TEXT) spill();
				end
				DS_AMP: begin
					if (was != DS_TEXT) spill();
					ent_n = 0;
					stash(c);
				end
				DS_DEC: begin
					stash(c);
					if (was == DS_HASH) begin
						acc      = '0;
						acc_prev = '0;
					end
					fold_digit(10, ACC_WIDTH_DEF'(c - CH_0));
				end
				DS_HEX: begin
					stash(c);
					if (was == DS_HEX_X) begin
						acc      = '0;
						acc_prev = '0;
					end
					if (c >= CH_0 && c <= CH_9) nib = ACC_WIDTH_DEF'(c - CH_0);
					else if (c >= CH_LA && c <= CH_LF) nib = c - CH_LA + 10;
					else nib = c - CH_UA + 10;
					fold_digit(16, nib);
				end
				default: stash(c);
			endcase
		end
		r.done = (parse_st == DS_CLOSED);
		r.err  = (parse_st == DS_ERROR);
		r.wide = wide_flag;
		r.ovf  = ovf_flag;
		if (emitted.size() == 0) begin
			r.ch       = '0;
			r.has      = 1'b0;
			r.last_run = 1'b1;
			decoded_q.push_back(r);
		end else begin
			for (int k = 0; k < emitted.size(); k++) begin
				r.ch       = emitted[k];
				r.has      = 1'b1;
				r.last_run = (k == emitted.size() - 1);
				decoded_q.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid        <= 1'b0;
			in_ch.in_char      <= '0;
			in_ch.start_string <= 1'b0;
			gap_n              <= 0;
			calm_in            <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) decode_unit(in_ch.in_char, in_ch.start_string);
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_n != 0) begin
					gap_n       <= gap_n - 1;
					in_ch.valid <= 1'b0;
				end else if (units_q.size() != 0) begin
					next_unit           = units_q.pop_front();
					in_ch.valid        <= 1'b1;
					in_ch.in_char      <= next_unit.ch;
					in_ch.start_string <= next_unit.restart;
					gap_n              <= calm_in ? 0 : $urandom_range(0, 4);
					if ($urandom_range(0, 23) == 0) calm_in <= ~calm_in;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	function automatic string show(input dec_result_t r);
		return $sformatf("char=%h has=%b last=%b done=%b err=%b wide=%b ovf=%b",
			r.ch, r.has, r.last_run, r.done, r.err, r.wide, r.ovf);
	endfunction

	task automatic note_mismatch(input string why, input string wanted, input dec_result_t seen);
		mismatch_n++;
		if (mismatch_n <= 10)
			$display("%0t mismatch, %s: expected %s, got %s", $time, why, wanted, show(seen));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_n       <= 0;
			calm_out     <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got.ch       = out_ch.out_char;
				got.has      = out_ch.has_char;
				got.last_run = out_ch.last_of_run;
				got.done     = out_ch.string_done;
				got.err      = out_ch.syntax_error;
				got.wide     = out_ch.wide_entity;
				got.ovf      = out_ch.buffer_overflow;
				if (decoded_q.size() == 0) begin
					note_mismatch("unexpected item", "nothing", got);
				end else begin
					want = decoded_q.pop_front();
					if (want.ch !== got.ch || want.has !== got.has ||
							want.last_run !== got.last_run || want.done !== got.done ||
							want.err !== got.err || want.wide !== got.wide ||
							want.ovf !== got.ovf)
						note_mismatch("wrong item", show(want), got);
				end
				wait_n        = calm_out ? 0 : $urandom_range(0, 4);
				hold_n       <= wait_n;
				out_ch.ready <= (wait_n == 0);
				if ($urandom_range(0, 23) == 0) calm_out <= ~calm_out;
			end else if (hold_n != 0) begin
				hold_n       <= hold_n - 1;
				out_ch.ready <= (hold_n == 1);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic add_unit(input char_t c, input logic restart);
		unit_t u;
		u.ch      = c;
		u.restart = restart;
		units_q.push_back(u);
		queued_n++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_unit(char_t'(s[i]), 1'b0);
	endtask

	function automatic string pick_name();
		case ($urandom_range(0, 4))
			0:       return "lt";
			1:       return "gt";
			2:       return "amp";
			3:       return "apos";
			default: return "quot";
		endcase
	endfunction

	function automatic char_t delimiter();
		if (char_t'(quote_cfg) == CH_APOS) return CH_APOS;
		if (char_t'(quote_cfg) == CH_DQUOTE) return CH_DQUOTE;
		return $urandom_range(0, 1) ? CH_APOS : CH_DQUOTE;
	endfunction

	task automatic add_plain();
		case ($urandom_range(0, 7))
			0:       add_unit(char_t'($urandom_range(0, 16'hFFFF)), 1'b0);
			1:       add_unit((char_t'(quote_cfg) == CH_DQUOTE) ? CH_APOS : CH_DQUOTE, 1'b0);
			default: add_unit(char_t'(plain_chars[$urandom_range(0, plain_chars.len() - 1)]),
				1'b0);
		endcase
	endtask

	task automatic add_number();
		logic        hexa;
		int unsigned len;
		hexa = 1'($urandom_range(0, 1));
		// long runs can overflow the accumulator and the entity store
		len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 4);
		add_unit(CH_AMP, 1'b0);
		add_unit(CH_HASH, 1'b0);
		if (hexa) add_unit(CH_LX, 1'b0);
		repeat (len) begin
			if (hexa) add_unit(char_t'(hex_digits[$urandom_range(0, 21)]), 1'b0);
			else add_unit(CH_0 + char_t'($urandom_range(0, 9)), 1'b0);
		end
		if ($urandom_range(0, 9) != 0) add_unit(CH_SEMI, 1'b0);
	endtask

	task automatic add_broken();
		string       nm;
		int unsigned cut;
		int unsigned pick;
		add_unit(CH_AMP, 1'b0);
		if ($urandom_range(0, 2) != 0) begin
			nm  = pick_name();
			cut = $urandom_range(0, nm.len() - 1);
			if (cut != 0) add_text(nm.substr(0, cut - 1));
		end else begin
			add_unit(CH_HASH, 1'b0);
			if ($urandom_range(0, 1)) add_unit(CH_LX, 1'b0);
		end
		pick = $urandom_range(0, 9);
		if (pick <= 2) add_unit(CH_SEMI, 1'b0);
		else if (pick <= 5) add_plain();
		else if (pick <= 7) add_unit(CH_AMP, 1'b0);
		else if (pick == 8) add_unit(delimiter(), 1'b0);
	endtask

	task automatic add_string();
		char_t       delim;
		int unsigned pick;
		delim = delimiter();
		add_unit(delim, $urandom_range(0, 9) != 0);
		repeat ($urandom_range(0, 8)) begin
			pick = $urandom_range(0, 9);
			if (pick <= 4) add_plain();
			else if (pick <= 6) begin
				add_unit(CH_AMP, 1'b0);
				add_text(pick_name());
				add_unit(CH_SEMI, 1'b0);
			end else if (pick == 7) add_number();
			else add_broken();
		end
		if ($urandom_range(0, 7) != 0) add_unit(delim, 1'b0);
		if ($urandom_range(0, 7) == 0) add_plain();
	endtask

	task automatic add_random(input int unsigned target);
		queued_n = 0;
		while (queued_n < target) begin
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 4))
					add_unit(char_t'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3) == 0);
			end else begin
				add_string();
			end
		end
	endtask

	task automatic settle();
		do @(negedge clk);
		while (units_q.size() != 0 || in_ch.valid || decoded_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_quote(input quote_t q);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= q;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		quote_cfg    = q;
		@(negedge clk);
	endtask

	initial begin
		cfg_wr_en   = 1'b0;
		cfg_wr_data = QUOTE_RESET;
		mismatch_n  = 0;
		queued_n    = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		set_quote(QUOTE_RESET);

		add_unit(CH_DQUOTE, 1'b1);
		add_unit(CH_AMP, 1'b0);
		add_text("lt;");
		add_unit(CH_AMP, 1'b0);
		add_text("#xFfFf;");
		add_unit(CH_AMP, 1'b0);
		add_text("am;");
		add_unit(16'hFFFF, 1'b0);
		add_unit(16'h0000, 1'b0);
		add_unit(CH_APOS, 1'b0);
		add_unit(CH_DQUOTE, 1'b0);
		// past the closing quote the parse drops into its error state and stays
		add_unit(CH_LX, 1'b0);
		add_unit(CH_DQUOTE, 1'b0);
		add_unit(CH_APOS, 1'b1);
		settle();

		set_quote(quote_t'(CH_APOS));
		add_random(60);
		settle();

		// neither quote delimits here
		set_quote(quote_t'($urandom_range(35, 38)));
		add_random(20);
		settle();

		set_quote(quote_t'(CH_DQUOTE));
		add_random(60);
		settle();

		set_quote(quote_t'(CH_APOS));
		add_random(40);
		settle();
		repeat (16) @(posedge clk);

		if (mismatch_n == 0 && decoded_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
src/xqsed_pkg.sv
src/xqsed_if.sv
src/xqsed_ram.sv
src/xqsed_alu.sv
src/xml_quoted_string_entity_decoder.sv
bench/tb.sv
